// ===== rtl/kst_pkg.sv =====
`timescale 1ns / 1ps
package kst_pkg;
	localparam int MaxVertices = 32;
	localparam int MaxEdges    = 256;
	localparam int WeightBits  = 16;
	localparam int VtxW        = $clog2(MaxVertices);
	localparam int EdgeAw      = $clog2(MaxEdges);
	localparam int CntW        = EdgeAw + 1;

	typedef struct packed {
		logic [4:0]         edge_origin;
		logic [4:0]         edge_end;
		logic signed [15:0] edge_weight;
		logic               last_edge;
	} kst_in_t;

	typedef struct packed {
		logic [4:0]         tree_origin;
		logic [4:0]         tree_end;
		logic signed [15:0] tree_weight;
		logic               has_edge;
		logic               spanning;
		logic               last_result;
	} kst_out_t;

	typedef struct packed {
		logic [VtxW-1:0]          origin;
		logic [VtxW-1:0]          dest;
		logic signed [WeightBits-1:0] weight;
	} kst_edge_t;

	typedef enum logic [3:0] {
		ST_LOAD, ST_SORT_RD, ST_SORT_KEY, ST_SORT_CMP, ST_SORT_WR,
		ST_LBL_INIT, ST_SCAN_RD, ST_SCAN_EVAL, ST_LBL_A, ST_LBL_B, ST_RELABEL, ST_FINISH
	} kst_state_t;
endpackage

// ===== rtl/kruskal_spanning_tree_core.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Signals
// input   | in        | start, busy, item (kst_in_t)
// result  | out       | result_valid, result (kst_out_t)
// config  | in        | cfg_valid, cfg_ready, cfg_data
// Edges are accepted while busy is low. The last edge starts an
// insertion sort of the edge memory by ascending weight (O(E^2) worst
// case), then a label init over all MaxVertices labels, then a scan of
// the edges with a relabel pass over the active vertices per tree edge and
// a closing state; busy is high throughout.
// Reset clears control only; the memories need no clearing.
// Results cannot be stalled: each is shown for one cycle with result_valid.
module kruskal_spanning_tree_core
	import kst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  kst_in_t    item,
	output logic       result_valid,
	output kst_out_t   result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [5:0] cfg_data
);
	kst_state_t state_q, state_d;
	logic [5:0]        vcount_q;
	logic [CntW-1:0]   total_q, i_q, j_q;
	logic [VtxW:0]     v_q;
	logic [VtxW-1:0]   found_q;
	kst_edge_t         key_q, rd_s1, cur_q;
	logic [VtxW-1:0]   la_q, lb_q;
	logic [VtxW-1:0]   lbl_rd_s1;
	logic              res_v_q;
	kst_out_t          res_q;
	logic              hold_v_q;
	kst_out_t          hold_q;

	kst_edge_t edge_mem [MaxEdges];
	logic [VtxW-1:0] lbl_mem [MaxVertices];

	// Active vertex count, clamped.
	logic [VtxW:0] n_act;
	always_comb begin
		if (vcount_q == 6'd0) n_act = (VtxW+1)'(1);
		else if (vcount_q > 6'(MaxVertices)) n_act = (VtxW+1)'(MaxVertices);
		else n_act = (VtxW+1)'(vcount_q);
	end
	logic [VtxW-1:0] need;
	assign need = VtxW'(n_act - 1'b1);

	assign busy = (state_q != ST_LOAD);
	assign cfg_ready = !busy;
	logic accept;
	assign accept = start && !busy;
	logic store_ok;
	assign store_ok = ({1'b0, item.edge_origin} < n_act) && ({1'b0, item.edge_end} < n_act)
		&& (total_q < CntW'(MaxEdges));

	// Edge and label memory port control, and result emission.
	logic            e_we;
	logic [EdgeAw-1:0] e_wa, e_ra;
	kst_edge_t       e_wd;
	logic            l_we;
	logic [VtxW-1:0] l_wa, l_ra, l_wd;
	logic            emit;
	kst_out_t        emit_d;

	always_comb begin
		state_d = state_q;
		e_we = 1'b0; e_wa = '0; e_wd = key_q; e_ra = '0;
		l_we = 1'b0; l_wa = v_q[VtxW-1:0]; l_wd = v_q[VtxW-1:0]; l_ra = v_q[VtxW-1:0];
		emit = 1'b0; emit_d = '0;
		case (state_q)
			ST_LOAD: begin
				e_we = accept && store_ok;
				e_wa = total_q[EdgeAw-1:0];
				e_wd = '{item.edge_origin, item.edge_end, item.edge_weight};
				if (accept && item.last_edge) state_d = ST_SORT_RD;
			end
			ST_SORT_RD: begin
				// Read the key element i.
				e_ra = i_q[EdgeAw-1:0];
				if (i_q >= total_q) state_d = ST_LBL_INIT;
				else state_d = ST_SORT_KEY;
			end
			ST_SORT_KEY: begin
				e_ra = EdgeAw'(j_q - 1'b1);
				state_d = ST_SORT_CMP;
			end
			ST_SORT_CMP: begin
				// Shift a heavier predecessor up, or place the key.
				if (j_q != '0 && rd_s1.weight > key_q.weight) begin
					e_we = 1'b1; e_wa = j_q[EdgeAw-1:0]; e_wd = rd_s1;
					e_ra = EdgeAw'(j_q - 2'd2);
					state_d = ST_SORT_WR;
				end else begin
					e_we = 1'b1; e_wa = j_q[EdgeAw-1:0]; e_wd = key_q;
					state_d = ST_SORT_RD;
				end
			end
			ST_SORT_WR: begin
				e_ra = EdgeAw'(j_q - 1'b1);
				state_d = ST_SORT_CMP;
			end
			ST_LBL_INIT: begin
				l_we = 1'b1;
				if (v_q == (VtxW+1)'(MaxVertices - 1)) state_d = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				e_ra = i_q[EdgeAw-1:0];
				if (found_q == need || i_q >= total_q) state_d = ST_FINISH;
				else state_d = ST_SCAN_EVAL;
			end
			ST_SCAN_EVAL: begin
				// Look up the label of the origin.
				l_ra = rd_s1.origin;
				state_d = ST_LBL_A;
			end
			ST_LBL_A: begin
				// Look up the label of the other endpoint.
				l_ra = cur_q.dest;
				state_d = ST_LBL_B;
			end
			ST_LBL_B: begin
				// Different labels join the tree; the held tree edge goes out now.
				if (lbl_rd_s1 != la_q) begin
					emit = hold_v_q;
					emit_d = hold_q;
					state_d = ST_RELABEL;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_RELABEL: begin
				// v_q walks reads; write lags by one with lbl_rd_s1.
				if (v_q != '0 && lbl_rd_s1 == lb_q) begin
					l_we = 1'b1; l_wa = VtxW'(v_q - 1'b1); l_wd = la_q;
				end
				if (v_q == n_act) state_d = ST_SCAN_RD;
			end
			ST_FINISH: begin
				emit = 1'b1;
				if (found_q == '0) begin
					emit_d = '0; emit_d.last_result = 1'b1;
					emit_d.spanning = (need == '0);
				end else begin
					emit_d = hold_q; emit_d.last_result = 1'b1;
					emit_d.spanning = (found_q == need);
				end
				state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Memories.
	always_ff @(posedge clk) begin
		if (e_we) edge_mem[e_wa] <= e_wd;
		rd_s1 <= edge_mem[e_ra];
		if (l_we) lbl_mem[l_wa] <= l_wd;
		lbl_rd_s1 <= lbl_mem[l_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			vcount_q <= 6'd32;
			total_q <= '0; i_q <= '0; j_q <= '0; v_q <= '0;
			found_q <= '0; res_v_q <= 1'b0; res_q <= '0;
			hold_v_q <= 1'b0; hold_q <= '0;
		end else begin
			state_q <= state_d;
			res_v_q <= 1'b0;
			if (cfg_valid && cfg_ready) vcount_q <= cfg_data;
			case (state_q)
				ST_LOAD: begin
					if (accept && store_ok) total_q <= total_q + 1'b1;
					i_q <= CntW'(1);
					v_q <= '0;
				end
				ST_SORT_RD: begin
					j_q <= i_q;
					if (i_q >= total_q) v_q <= '0;
				end
				ST_SORT_KEY: key_q <= rd_s1;
				ST_SORT_CMP: begin
					if (j_q != '0 && rd_s1.weight > key_q.weight) j_q <= j_q - 1'b1;
					else i_q <= i_q + 1'b1;
				end
				ST_LBL_INIT: begin
					v_q <= v_q + 1'b1;
					i_q <= '0; found_q <= '0;
					hold_v_q <= 1'b0;
				end
				ST_SCAN_EVAL: begin
					cur_q <= rd_s1;
					i_q <= i_q + 1'b1;
				end
				ST_LBL_A: la_q <= lbl_rd_s1;
				ST_LBL_B: begin
					lb_q <= lbl_rd_s1;
					v_q <= '0;
					// A new tree edge is held until the next one or the end.
					if (lbl_rd_s1 != la_q) begin
						hold_q <= '{cur_q.origin, cur_q.dest, cur_q.weight, 1'b1, 1'b0, 1'b0};
						hold_v_q <= 1'b1;
						found_q <= found_q + 1'b1;
					end
				end
				ST_RELABEL: begin
					v_q <= v_q + 1'b1;
				end
				ST_FINISH: begin
					total_q <= '0;
					found_q <= '0;
					hold_v_q <= 1'b0;
				end
				default: ;
			endcase
			if (emit) begin
				res_v_q <= 1'b1;
				res_q <= emit_d;
			end
		end
	end

	// Results come straight from the output register.
	assign result_valid = res_v_q;
	assign result = res_q;

	property p_busy_after_last;
		@(posedge clk) disable iff (!arst_n) (accept && item.last_edge) |=> busy;
	endproperty
	assert property (p_busy_after_last) else $error("not busy after last edge");
	property p_no_result_idle;
		@(posedge clk) disable iff (!arst_n) (!busy && !$past(busy)) |-> !result_valid;
	endproperty
	assert property (p_no_result_idle) else $error("result while idle");
	property p_total_bound;
		@(posedge clk) disable iff (!arst_n) total_q <= CntW'(MaxEdges);
	endproperty
	assert property (p_total_bound) else $error("edge count overflow");
endmodule
